/* design/avd_pkg.sv */
// Shared widths, step counts and the seven-segment encoding for the
// auto-ranging voltmeter display. No dependencies.
package avd_pkg;

  localparam int CODE_W     = 10;
  localparam int FS_W       = 24;
  localparam int READ_W     = 24;
  localparam int DIGITS     = 8;
  localparam int BCD_W      = 4 * DIGITS;
  localparam int POS_W      = 2;
  localparam int SEL_W      = 4;
  localparam int SEG_W      = 8;
  localparam int MUL_CNT_W  = 4;
  localparam int BCD_CNT_W  = 5;
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(CODE_W - 1);
  localparam logic [BCD_CNT_W-1:0] BCD_LAST = BCD_CNT_W'(READ_W - 1);
  localparam logic [FS_W-1:0]      FS_RESET = FS_W'(5000);
  localparam logic [SEG_W-1:0]     SEG_POINT = 8'h80;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  function automatic logic [SEG_W-1:0] seg_encode(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0: s = 8'h3F;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5B;
      4'd3: s = 8'h4F;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6D;
      4'd6: s = 8'h7D;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

/* design/avd_mul.sv */
// Bit-serial shift-add multiplier: one converter code bit per cycle.
// Depends on avd_pkg.
module avd_mul
  import avd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CODE_W-1:0] code,
  input  logic [FS_W-1:0]   full_scale,
  output logic              done,
  output logic [READ_W-1:0] product
);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [FS_W-1:0]      hi;
  logic [CODE_W-1:0]    lo;
  logic [FS_W-1:0]      fs_q;
  logic [FS_W:0]        sum;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, fs_q} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        hi   <= '0;
        lo   <= code;
        fs_q <= full_scale;
      end else if (busy) begin
        // product shifts right through hi:lo; after the last step hi = prod >> 10
        hi  <= sum[FS_W:1];
        lo  <= {sum[0], lo[CODE_W-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == MUL_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = hi;

endmodule

/* design/avd_bcd.sv */
// Serial binary-to-BCD converter (shift and add three), one bit per cycle.
// Depends on avd_pkg.
module avd_bcd
  import avd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [READ_W-1:0] bin,
  output logic              done,
  output logic [BCD_W-1:0]  bcd
);

  logic                 busy;
  logic [BCD_CNT_W-1:0] cnt;
  logic [READ_W-1:0]    sh;
  logic [BCD_W-1:0]     adj;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      bcd  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        sh   <= bin;
        bcd  <= '0;
      end else if (busy) begin
        bcd <= {adj[BCD_W-2:0], sh[READ_W-1]};
        sh  <= {sh[READ_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == BCD_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/autorange_voltmeter_display_scan.sv */
// Auto-ranging voltmeter display scanner: top level with control and output word.
// After a sample word is taken, no further word is taken until the conversion ends:
// load, 10 multiply steps, load, 24 BCD steps and the return to idle.
// A tick word is taken in any idle cycle with a free output slot; its result
// is registered into the output word, so ticks run back to back at one per cycle while the slot stays free.
// Synchronous reset: BCD reading 0, scan position 0, full scale 5000 mV, output empty.
module autorange_voltmeter_display_scan
  import avd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [15:0]     s_axis_tdata,   // [9:0] sample, rest zero
  input  logic            s_axis_tuser,   // [0] action
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [15:0]     m_axis_tdata,   // [7:0] segments, [11:8] digit_select
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [FS_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_BCD  = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [FS_W-1:0]   full_scale;
  logic [POS_W-1:0]  scan_pos;
  logic              out_valid;
  logic [SEG_W-1:0]  out_seg;
  logic [SEL_W-1:0]  out_sel;

  logic              take, take_sample, take_tick, slot_free;
  logic              mul_done, bcd_done;
  logic [READ_W-1:0] reading;
  logic [BCD_W-1:0]  bcd;

  logic [1:0]        range;
  logic [2:0]        expo;
  logic [3:0]        digit;
  logic [SEG_W-1:0]  seg_next;
  logic [SEL_W-1:0]  sel_next;

  assign cfg_ready = 1'b1;

  // samples need no output slot; ticks wait for one
  assign slot_free     = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && ((s_axis_tuser == ACT_SAMPLE) || slot_free);
  assign take          = s_axis_tvalid && s_axis_tready;
  assign take_sample   = take && (s_axis_tuser == ACT_SAMPLE);
  assign take_tick     = take && (s_axis_tuser == ACT_TICK);

  avd_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (take_sample),
    .code      (s_axis_tdata[CODE_W-1:0]),
    .full_scale(full_scale),
    .done      (mul_done),
    .product   (reading)
  );

  avd_bcd u_bcd (
    .clk  (clk),
    .rst  (rst),
    .start(mul_done),
    .bin  (reading),
    .done (bcd_done),
    .bcd  (bcd)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (take_sample) state_next = ST_MUL;
      ST_MUL:  if (mul_done)    state_next = ST_BCD;
      ST_BCD:  if (bcd_done)    state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // range from the leading decimal digits of the reading
  always_comb begin
    if (bcd[31:24] != '0)      range = 2'd3;
    else if (bcd[23:20] != '0) range = 2'd2;
    else if (bcd[19:16] != '0) range = 2'd1;
    else                       range = 2'd0;
    expo     = 3'd3 + {1'b0, range} - {1'b0, scan_pos};
    digit    = bcd[{expo, 2'b00} +: 4];
    seg_next = seg_encode(digit) | ((scan_pos == range) ? SEG_POINT : '0);
    sel_next = ~(SEL_W'(4'b1000) >> scan_pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      full_scale <= FS_RESET;
      scan_pos   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        full_scale <= cfg_data;
      end
      if (take_tick) begin
        out_valid <= 1'b1;
        out_seg   <= seg_next;
        out_sel   <= sel_next;
        scan_pos  <= scan_pos + 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_sel, out_seg};

endmodule

/* design/avd_chk.sv */
// Port-level checker for the voltmeter display scanner, bound to the top level.
// Depends on autorange_voltmeter_display_scan.
module avd_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output word present after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  a_one_digit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $countones(m_axis_tdata[11:8]) == 3 && m_axis_tdata[15:12] == 4'b0000)
    else $error("digit select not exactly one active digit");

  a_seg_lit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[6:0] != 7'b0000000)
    else $error("blank digit segments");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
    else $error("input taken during conversion");

endmodule

bind autorange_voltmeter_display_scan avd_chk u_avd_chk (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
